[rtl/core/assert_macros.svh]
// assertion macros for the nearest centroid assignment rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nca assertion failed");

// next-cycle implication
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nca assertion failed");

`else

`define NCA_ASSERT_SAME(label, clk, rst, ante, cons)
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/nca_pkg.sv]
// package with widths, codes and types of the nearest centroid assignment block
package nca_pkg;

   localparam int MAX_CENTROIDS_DEF = 16;
   localparam int MAX_FEATURES_DEF  = 32;

   localparam int ACTION_W   = 1;
   localparam int CIDX_W     = 4;
   localparam int FIDX_W     = 5;
   localparam int COORD_W    = 16;
   localparam int NIDX_W     = 4;
   localparam int DIST_W     = 37;
   localparam int SQ_W       = 33;
   localparam int K_CFG_W    = 5;
   localparam int D_CFG_W    = 6;
   localparam int CSR_DATA_W = 6;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 1'b0,
      ACT_POINT = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      CSR_CENTROID_COUNT = 1'b0,
      CSR_FEATURE_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic p1_valid;
      logic p2_valid;
      logic p2_first;
      logic restart;
   } pipe_ctl_type;

endpackage

[rtl/core/nca_ram.sv]
// generic simple dual-port ram with registered read
module nca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/nca_dist_unit.sv]
// shared subtract, square, saturating accumulate and running minimum unit
module nca_dist_unit #(
   parameter int CW = 4
) (
   input  logic                              clock,
   input  nca_pkg::pipe_ctl_type             ctl,
   input  logic signed [nca_pkg::COORD_W-1:0] pt_val,
   input  logic [nca_pkg::COORD_W-1:0]       cen_val,
   input  logic [nca_pkg::DIST_W-1:0]        part_val,
   input  logic                              part_ok,
   input  logic [CW-1:0]                     p2_idx,
   output logic [nca_pkg::DIST_W-1:0]        sum_sat,
   output logic [nca_pkg::DIST_W-1:0]        best_dist,
   output logic [CW-1:0]                     best_idx
);

   import nca_pkg::*;

   logic signed [COORD_W:0]     diff;
   logic signed [2*COORD_W+1:0] prod;
   logic [SQ_W-1:0]             sq_ff;
   logic [SQ_W-1:0]             sq_in;
   logic [DIST_W-1:0]           base;
   logic [DIST_W:0]             sum_wide;
   logic [DIST_W-1:0]           best_dist_ff;
   logic [DIST_W-1:0]           best_dist_in;
   logic [CW-1:0]               best_idx_ff;
   logic [CW-1:0]               best_idx_in;

   always_comb begin
      diff  = {pt_val[COORD_W-1], pt_val} - {cen_val[COORD_W-1], cen_val};
      prod  = diff * diff;
      sq_in = prod[SQ_W-1:0];
   end

   always_comb begin
      base     = part_ok ? part_val : '0;
      sum_wide = {1'b0, base} + (DIST_W+1)'(sq_ff);
      sum_sat  = (sum_wide > {1'b0, DIST_MAX}) ? DIST_MAX : sum_wide[DIST_W-1:0];
   end

   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (ctl.p2_valid && (ctl.p2_first || (sum_sat < best_dist_ff))) begin
         best_dist_in = sum_sat;
         best_idx_in  = p2_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.p1_valid) begin
         sq_ff <= sq_in;
      end
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_dist = best_dist_ff;
   assign best_idx  = best_idx_ff;

endmodule

[rtl/core/nca_seq.sv]
// sequencer that walks the active centroids through the distance unit
module nca_seq #(
   parameter int MAX_FEATURES  = 32,
   parameter int CW            = 4,
   parameter int AW            = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [nca_pkg::K_CFG_W-1:0]       eff_k,
   input  logic [nca_pkg::D_CFG_W-1:0]       eff_d,
   input  logic                              req_valid,
   input  logic [nca_pkg::ACTION_W-1:0]      req_action,
   input  logic [nca_pkg::FIDX_W-1:0]        req_feature_index,
   input  logic signed [nca_pkg::COORD_W-1:0] req_coord_value,
   input  logic                              rsp_free,
   output logic                              req_ready,
   output nca_pkg::pipe_ctl_type             ctl,
   output logic signed [nca_pkg::COORD_W-1:0] pt_val,
   output logic                              cen_rd_en,
   output logic [AW-1:0]                     cen_rd_addr,
   output logic [CW-1:0]                     p1_idx,
   output logic [CW-1:0]                     p2_idx,
   output logic                              resp_load
);

   import nca_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic signed [COORD_W-1:0] pt_val_ff, pt_val_in;
   logic                 restart_ff, restart_in;
   logic                 emit_ff, emit_in;
   logic                 p1_valid_ff, p1_valid_in;
   logic                 p1_last_ff, p1_last_in;
   logic [CW-1:0]        p1_idx_ff, p1_idx_in;
   logic                 p2_valid_ff;
   logic                 p2_last_ff;
   logic [CW-1:0]        p2_idx_ff;
   logic                 start;
   logic                 cnt_last;

   assign req_ready = (state_ff == S_IDLE);
   assign start     = req_valid && req_ready && (req_action == ACT_POINT)
                      && (D_CFG_W'(req_feature_index) < eff_d);
   assign cnt_last  = (int'(cnt_ff) == int'(eff_k) - 1);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      pt_val_in   = pt_val_ff;
      restart_in  = restart_ff;
      emit_in     = emit_ff;
      p1_valid_in = 1'b0;
      p1_last_in  = 1'b0;
      p1_idx_in   = cnt_ff;
      cen_rd_en   = 1'b0;
      resp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = S_RUN;
               cnt_in     = '0;
               addr_in    = AW'(req_feature_index);
               pt_val_in  = req_coord_value;
               restart_in = (req_feature_index == '0);
               emit_in    = (D_CFG_W'(req_feature_index) == eff_d - 1'b1);
            end
         end
         S_RUN: begin
            cen_rd_en   = 1'b1;
            p1_valid_in = 1'b1;
            p1_last_in  = cnt_last;
            if (cnt_last) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in  = CW'(cnt_ff + 1'b1);
               addr_in = AW'(addr_ff + AW'(MAX_FEATURES));
            end
         end
         S_DRAIN: begin
            if (p2_valid_ff && p2_last_ff) begin
               state_in = emit_ff ? S_RESP : S_IDLE;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               resp_load = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
      end
      cnt_ff     <= cnt_in;
      addr_ff    <= addr_in;
      pt_val_ff  <= pt_val_in;
      restart_ff <= restart_in;
      emit_ff    <= emit_in;
      p1_last_ff <= p1_last_in;
      p1_idx_ff  <= p1_idx_in;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
   end

   assign ctl.p1_valid = p1_valid_ff;
   assign ctl.p2_valid = p2_valid_ff;
   assign ctl.p2_first = (p2_idx_ff == '0);
   assign ctl.restart  = restart_ff;
   assign pt_val       = pt_val_ff;
   assign cen_rd_addr  = addr_ff;
   assign p1_idx       = p1_idx_ff;
   assign p2_idx       = p2_idx_ff;

endmodule

[rtl/core/nearest_centroid_assign.sv]
// Nearest centroid assignment (k-means assignment step). A load transaction
// writes one centroid coordinate. A point transaction brings one coordinate;
// the block walks the k active centroids through one subtract, square and
// accumulate unit, one centroid per cycle, reading the centroid store and the
// running-sum store once each per centroid; no new request is taken until the
// walk is done. The last coordinate also hands the nearest index and its
// distance to the response register, waiting while that register still holds
// an untaken result; a point coordinate beyond the configured coordinate count
// is accepted and dropped. The response register lets loads proceed while a
// result waits to be taken.
`include "assert_macros.svh"

module nearest_centroid_assign #(
   parameter int MAX_CENTROIDS = nca_pkg::MAX_CENTROIDS_DEF,
   parameter int MAX_FEATURES  = nca_pkg::MAX_FEATURES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  nca_pkg::csr_index_type             csr_index,
   input  logic [nca_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [nca_pkg::ACTION_W-1:0]       req_action,
   input  logic [nca_pkg::CIDX_W-1:0]         req_centroid_index,
   input  logic [nca_pkg::FIDX_W-1:0]         req_feature_index,
   input  logic signed [nca_pkg::COORD_W-1:0] req_coord_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nca_pkg::NIDX_W-1:0]         rsp_nearest_index,
   output logic [nca_pkg::DIST_W-1:0]         rsp_min_distance
);

   import nca_pkg::*;

   localparam int CW    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int DEPTH = MAX_CENTROIDS * MAX_FEATURES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [K_CFG_W-1:0]        k_ff, eff_k;
   logic [D_CFG_W-1:0]        d_ff, eff_d;
   pipe_ctl_type              ctl;
   logic signed [COORD_W-1:0] pt_val;
   logic                      cen_rd_en;
   logic [AW-1:0]             cen_rd_addr;
   logic                      cen_wr_en;
   logic [AW-1:0]             cen_wr_addr;
   logic [COORD_W-1:0]        cen_rd_data;
   logic [CW-1:0]             p1_idx;
   logic [CW-1:0]             p2_idx;
   logic [DIST_W-1:0]         part_rd_data;
   logic [DIST_W-1:0]         sum_sat;
   logic [DIST_W-1:0]         best_dist;
   logic [CW-1:0]             best_idx;
   logic                      resp_load;
   logic                      rsp_free;
   logic                      part_ok;
   logic [MAX_CENTROIDS-1:0]  seen_ff, seen_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NIDX_W-1:0]         rsp_idx_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_CFG_W'(1);
         d_ff <= D_CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTROID_COUNT: k_ff <= csr_wdata[K_CFG_W-1:0];
            CSR_FEATURE_COUNT:  d_ff <= csr_wdata[D_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_k = k_ff;
      if (k_ff == '0) begin
         eff_k = K_CFG_W'(1);
      end else if (int'(k_ff) > MAX_CENTROIDS) begin
         eff_k = K_CFG_W'(MAX_CENTROIDS);
      end
      eff_d = d_ff;
      if (d_ff == '0) begin
         eff_d = D_CFG_W'(1);
      end else if (int'(d_ff) > MAX_FEATURES) begin
         eff_d = D_CFG_W'(MAX_FEATURES);
      end
   end

   // centroid loads
   assign cen_wr_en = req_valid && req_ready && (req_action == ACT_LOAD)
                      && (int'(req_centroid_index) < MAX_CENTROIDS)
                      && (int'(req_feature_index) < MAX_FEATURES);
   assign cen_wr_addr = AW'(int'(req_centroid_index) * MAX_FEATURES
                            + int'(req_feature_index));

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   nca_seq #(
      .MAX_FEATURES  (MAX_FEATURES),
      .CW            (CW),
      .AW            (AW)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .eff_k             (eff_k),
      .eff_d             (eff_d),
      .req_valid         (req_valid),
      .req_action        (req_action),
      .req_feature_index (req_feature_index),
      .req_coord_value   (req_coord_value),
      .rsp_free          (rsp_free),
      .req_ready         (req_ready),
      .ctl               (ctl),
      .pt_val            (pt_val),
      .cen_rd_en         (cen_rd_en),
      .cen_rd_addr       (cen_rd_addr),
      .p1_idx            (p1_idx),
      .p2_idx            (p2_idx),
      .resp_load         (resp_load)
   );

   nca_ram #(
      .WIDTH (COORD_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_cen_ram (
      .clock   (clock),
      .wr_en   (cen_wr_en),
      .wr_addr (cen_wr_addr),
      .wr_data (req_coord_value),
      .rd_en   (cen_rd_en),
      .rd_addr (cen_rd_addr),
      .rd_data (cen_rd_data)
   );

   nca_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_CENTROIDS),
      .AW    (CW)
   ) u_part_ram (
      .clock   (clock),
      .wr_en   (ctl.p2_valid),
      .wr_addr (p2_idx),
      .wr_data (sum_sat),
      .rd_en   (ctl.p1_valid),
      .rd_addr (p1_idx),
      .rd_data (part_rd_data)
   );

   // running sums read as zero until first written and on the first coordinate of a point
   always_comb begin
      seen_in = seen_ff;
      if (ctl.p2_valid) begin
         seen_in[p2_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign part_ok = seen_ff[p2_idx] && !ctl.restart;

   nca_dist_unit #(
      .CW (CW)
   ) u_dist (
      .clock     (clock),
      .ctl       (ctl),
      .pt_val    (pt_val),
      .cen_val   (cen_rd_data),
      .part_val  (part_rd_data),
      .part_ok   (part_ok),
      .p2_idx    (p2_idx),
      .sum_sat   (sum_sat),
      .best_dist (best_dist),
      .best_idx  (best_idx)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (resp_load) begin
         rsp_idx_ff  <= NIDX_W'(best_idx);
         rsp_dist_ff <= best_dist;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_min_distance  = rsp_dist_ff;

   `NCA_ASSERT_SAME(a_pipe_empty_when_ready, clock, reset, req_ready, !ctl.p1_valid && !ctl.p2_valid)
   `NCA_ASSERT_SAME(a_no_ram_collision, clock, reset, cen_wr_en, !cen_rd_en)
   `NCA_ASSERT_NEXT(a_load_shows_result, clock, reset, resp_load, rsp_valid && req_ready)

endmodule

[test/nearest_centroid_assign_test.sv]
// testbench for nearest_centroid_assign: directed and random traffic checked against a predictor
`timescale 1ns / 100ps

module nearest_centroid_assign_test;
   import nca_pkg::*;

   localparam int MAX_K = MAX_CENTROIDS_DEF;
   localparam int MAX_D = MAX_FEATURES_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      logic [NIDX_W-1:0] idx;
      logic [DIST_W-1:0] distance;
   } nearest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_CENTROID_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACTION_W-1:0] req_action = ACT_LOAD;
   logic [CIDX_W-1:0] req_centroid_index = '0;
   logic [FIDX_W-1:0] req_feature_index = '0;
   logic [COORD_W-1:0] req_coord_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [NIDX_W-1:0] rsp_nearest_index;
   logic [DIST_W-1:0] rsp_min_distance;

   logic [COORD_W-1:0] centroid_coords [MAX_K][MAX_D];
   logic [DIST_W-1:0] running_dist [MAX_K];
   logic [K_CFG_W-1:0] centroid_count_cfg;
   logic [D_CFG_W-1:0] feature_count_cfg;
   nearest_type expected_nearest [$];

   int error_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit sender_idle_on = 1'b0;
   bit receiver_stall_on = 1'b0;

   nearest_centroid_assign u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_centroid_index (req_centroid_index),
      .req_feature_index  (req_feature_index),
      .req_coord_value    (req_coord_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_nearest_index  (rsp_nearest_index),
      .rsp_min_distance   (rsp_min_distance)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int idle_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int active_features();
      if (feature_count_cfg == 0) return 1;
      if (feature_count_cfg > MAX_D) return MAX_D;
      return int'(feature_count_cfg);
   endfunction

   function automatic void track_item(logic [ACTION_W-1:0] act, logic [CIDX_W-1:0] cidx,
                                      logic [FIDX_W-1:0] fidx, logic [COORD_W-1:0] coord);
      int k_eff;
      longint diff;
      longint total;
      nearest_type best;
      if (act == ACT_LOAD) begin
         centroid_coords[cidx][fidx] = coord;
         return;
      end
      k_eff = (centroid_count_cfg == 0) ? 1 :
              (centroid_count_cfg > MAX_K) ? MAX_K : int'(centroid_count_cfg);
      if (fidx >= active_features()) return;
      for (int i = 0; i < k_eff; i++) begin
         diff = longint'($signed(coord)) - longint'($signed(centroid_coords[i][fidx]));
         total = ((fidx == 0) ? 64'sd0 : longint'(running_dist[i])) + diff * diff;
         if (total > longint'(DIST_MAX)) total = longint'(DIST_MAX);
         running_dist[i] = DIST_W'(total);
      end
      if (fidx != active_features() - 1) return;
      best.idx = '0;
      best.distance = running_dist[0];
      for (int i = 1; i < k_eff; i++) begin
         if (running_dist[i] < best.distance) begin
            best.idx = NIDX_W'(i);
            best.distance = running_dist[i];
         end
      end
      expected_nearest.push_back(best);
   endfunction

   task automatic report_mismatch(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_item(action_type act, logic [CIDX_W-1:0] cidx,
                            logic [FIDX_W-1:0] fidx, logic [COORD_W-1:0] coord);
      int gap;
      gap = (sender_idle_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_centroid_index <= cidx;
      req_feature_index <= fidx;
      req_coord_value <= coord;
      do @(posedge clock); while (!req_ready);
      track_item(act, cidx, fidx, coord);
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_nearest.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type which, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (which == CSR_CENTROID_COUNT) centroid_count_cfg = value[K_CFG_W-1:0];
      else feature_count_cfg = value[D_CFG_W-1:0];
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] k_val, logic [CSR_DATA_W-1:0] d_val);
      quiesce();
      write_register(CSR_CENTROID_COUNT, k_val);
      write_register(CSR_FEATURE_COUNT, d_val);
   endtask

   task automatic fill_centroid_store();
      sender_idle_on = 1'b1;
      receiver_stall_on = 1'b1;
      for (int c = 0; c < MAX_K; c++)
         for (int f = 0; f < MAX_D; f++)
            send_item(ACT_LOAD, CIDX_W'(c), FIDX_W'(f), rand_coord());
   endtask

   task automatic test_nearest_and_ties();
      set_config(3, 2);
      send_item(ACT_LOAD, 4'd0, 5'd0, 16'h8000);
      send_item(ACT_LOAD, 4'd0, 5'd1, 16'h8000);
      send_item(ACT_LOAD, 4'd1, 5'd0, 16'h7fff);
      send_item(ACT_LOAD, 4'd1, 5'd1, 16'h7fff);
      send_item(ACT_LOAD, 4'd2, 5'd0, 16'h8000);
      send_item(ACT_LOAD, 4'd2, 5'd1, 16'h8000);
      send_item(ACT_POINT, 4'd0, 5'd0, 16'h7fff);
      send_item(ACT_POINT, 4'd0, 5'd1, 16'h7fff);
      // equal distance to centroids 0 and 2
      send_item(ACT_POINT, 4'd9, 5'd0, 16'h8000);
      send_item(ACT_POINT, 4'd6, 5'd1, 16'h8000);
      send_item(ACT_POINT, 4'd15, 5'd0, 16'h0000);
      send_item(ACT_POINT, 4'd0, 5'd1, 16'h0000);
      // coordinates beyond d are dropped
      send_item(ACT_POINT, 4'd15, 5'd5, 16'h1234);
      send_item(ACT_POINT, 4'd0, 5'd31, 16'hffff);
      send_item(ACT_POINT, 4'd0, 5'd0, 16'h7fff);
      send_item(ACT_POINT, 4'd0, 5'd1, 16'h8000);
   endtask

   task automatic test_register_limits();
      set_config(0, 0);
      send_item(ACT_POINT, 4'd0, 5'd0, 16'h7fff);
      send_item(ACT_POINT, 4'd0, 5'd1, 16'h8000);
      set_config(31, 63);
      send_item(ACT_POINT, 4'd0, 5'd0, 16'h8000);
      send_item(ACT_POINT, 4'd0, 5'd31, 16'h7fff);
   endtask

   task automatic test_saturation();
      set_config(1, 2);
      send_item(ACT_LOAD, 4'd0, 5'd1, 16'h8000);
      repeat (34) send_item(ACT_POINT, 4'd0, 5'd1, 16'h7fff);
      send_item(ACT_POINT, 4'd0, 5'd0, 16'h7fff);
      send_item(ACT_POINT, 4'd0, 5'd1, 16'h7fff);
   endtask

   task automatic random_phase(logic [CSR_DATA_W-1:0] k_val, logic [CSR_DATA_W-1:0] d_val,
                               int n_items, bit idle_on, bit stall_on);
      int sent;
      int d_eff;
      int count;
      int f;
      bit paused;
      set_config(k_val, d_val);
      sender_idle_on = idle_on;
      receiver_stall_on = stall_on;
      d_eff = active_features();
      sent = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if (!paused && sent >= n_items / 2) begin
            wait_results();
            paused = 1'b1;
         end
         case ($urandom_range(0, 19)) inside
            [0:2]: begin
               send_item(ACT_LOAD, CIDX_W'($urandom), FIDX_W'($urandom), rand_coord());
               sent++;
            end
            [3:5]: begin
               count = $urandom_range(1, 6);
               repeat (count) begin
                  f = $urandom_range(0, MAX_D - 1);
                  send_item(ACT_POINT, CIDX_W'($urandom), FIDX_W'(f), rand_coord());
                  sent++;
               end
            end
            6: begin
               f = $urandom_range(0, d_eff - 1);
               count = $urandom_range(2, 6);
               repeat (count) send_item(ACT_POINT, CIDX_W'($urandom), FIDX_W'(f), rand_coord());
               sent += count;
            end
            default: begin
               for (int i = 0; i < d_eff; i++)
                  send_item(ACT_POINT, CIDX_W'($urandom), FIDX_W'(i), rand_coord());
               sent += d_eff;
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      random_phase(1, 1, 100, 1'b1, 1'b1);
      random_phase(16, 32, 140, 1'b1, 1'b1);
      random_phase(4, 3, 110, 1'b0, 1'b0);
      random_phase(0, 0, 70, 1'b1, 1'b1);
      random_phase(31, 63, 120, 1'b1, 1'b1);
      random_phase(16, 2, 100, 1'b1, 1'b1);
      random_phase(CSR_DATA_W'($urandom_range(1, 16)), CSR_DATA_W'($urandom_range(1, 8)),
                   100, 1'b1, 1'b1);
      random_phase(3, 5, 100, 1'b1, 1'b0);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (receiver_stall_on && $urandom_range(0, 99) < 30) stall_left = idle_length();
      end
   end

   always @(posedge clock) begin
      nearest_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_nearest.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction index %0d distance %0d",
                                      rsp_nearest_index, rsp_min_distance));
         end else begin
            want = expected_nearest.pop_front();
            if (rsp_nearest_index !== want.idx)
               report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                         rsp_nearest_index, want.idx));
            if (rsp_min_distance !== want.distance)
               report_mismatch($sformatf("min_distance %0d, expected %0d",
                                         rsp_min_distance, want.distance));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      centroid_count_cfg = 1;
      feature_count_cfg = 1;
      foreach (running_dist[i]) running_dist[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fill_centroid_store();
      test_nearest_and_ties();
      test_register_limits();
      test_saturation();
      test_random_traffic();
      quiesce();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/nca_pkg.sv
rtl/core/nca_ram.sv
rtl/core/nca_dist_unit.sv
rtl/core/nca_seq.sv
rtl/core/nearest_centroid_assign.sv
test/nearest_centroid_assign_test.sv
